// ----- hw/rtl/dx80_pkg.sv -----
package dx80_pkg;

    // Operation codes
    localparam logic OP_WIDEN  = 1'b0;
    localparam logic OP_NARROW = 1'b1;

    // Format constants
    localparam logic [14:0] EXT_EXP_ONES  = 15'h7fff;
    localparam logic [14:0] EXT_REBIAS    = 15'd15360;  // 16383 - 1023
    localparam logic [14:0] EXT_SUB_BASE  = 15'd15372;  // 63 - 1074 + 16383
    localparam logic [63:0] EXT_INF_MAN   = 64'h8000_0000_0000_0000;
    localparam logic [63:0] EXT_NAN_MAN   = 64'hc000_0000_0000_0000;
    localparam logic [62:0] DBL_INF       = 63'h7ff0_0000_0000_0000;
    localparam logic [62:0] DBL_QNAN      = 63'h7ff8_0000_0000_0000;
    localparam logic signed [16:0] EXT_BIAS = 17'sd16383;

    typedef struct packed {
        logic        operation;
        logic [15:0] source_high;
        logic [63:0] source_low;
    } in_word_t;

    typedef struct packed {
        logic [15:0] result_high;
        logic [63:0] result_low;
    } out_word_t;

    // Working word carried down the pipeline
    typedef struct packed {
        logic               op;
        logic               sign;
        logic               fixed;   // result already final
        logic [15:0]        hi;
        logic [63:0]        lo;
        logic [14:0]        ex;
        logic [5:0]         lz;      // leading zeros, later the subnormal shift
        logic signed [16:0] ue;      // unbiased double exponent
        logic               inc;     // round-up pending
    } work_t;

endpackage

// ----- hw/rtl/dx80_stage.sv -----
module dx80_stage #(
    parameter int W = 8
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         in_valid,
    output logic         in_ready,
    input  logic [W-1:0] in_data,
    output logic         out_valid,
    input  logic         out_ready,
    output logic [W-1:0] out_data
);

    logic         valid_reg;
    logic [W-1:0] data_reg;

    // A stage takes a new word when empty or when its word moves on
    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= in_data;
        end
    end

endmodule

// ----- hw/rtl/double_extended80_converter_unit.sv -----
// Double / 80-bit extended converter.
// Input channel s_valid/s_ready/s_data carries one word per value: the
// operation (0 widen double to extended, 1 narrow extended to double), the
// extended sign/exponent and the 64-bit source. Output channel
// m_valid/m_ready/m_data returns one result word per input word, in order.
// A word passes from acceptance to m_valid through six register
// stages: input register, leading zero count, normalizing shift, 53-bit
// round with exponent range check, subnormal shift, final increment into
// the output register.
// Throughput is one word per cycle with m_ready high; every stage has its
// own valid bit and takes a new word whenever it is empty or its word
// moves on, so bubbles close up and the block keeps accepting while a
// result waits. When m_ready is low the output register holds its word
// and the stages behind it fill up; s_ready drops only once the whole
// pipeline is full. Nothing is lost or repeated across a stall.
// Synchronous active-low reset on aresetn clears all valid bits; the
// pipeline is empty and s_ready is high the cycle after reset is released.
module double_extended80_converter_unit (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  dx80_pkg::in_word_t s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output dx80_pkg::out_word_t m_data
);

    localparam int WI = $bits(dx80_pkg::in_word_t);
    localparam int WW = $bits(dx80_pkg::work_t);
    localparam int WO = $bits(dx80_pkg::out_word_t);

    dx80_pkg::in_word_t  iw;
    dx80_pkg::work_t     c1, c2, c3, c4;
    dx80_pkg::work_t     w2, w3, w4, w5;
    dx80_pkg::out_word_t c5;
    logic v1, v2, v3, v4, v5;
    logic r1, r2, r3, r4, r5;

    // Input register
    dx80_stage #(.W(WI)) u_s1 (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(s_valid), .in_ready(s_ready), .in_data(s_data),
        .out_valid(v1), .out_ready(r1), .out_data(iw)
    );

    // Classify and count leading zeros
    always_comb begin
        logic [10:0] ex11;
        logic [51:0] frac;
        c1      = '0;
        ex11    = iw.source_low[62:52];
        frac    = iw.source_low[51:0];
        c1.op   = iw.operation;
        if (iw.operation == dx80_pkg::OP_WIDEN) begin
            c1.sign = iw.source_low[63];
            if (ex11 == 11'd0 && frac == 52'd0) begin
                c1.fixed = 1'b1;
                c1.hi    = {c1.sign, 15'd0};
            end else if (ex11 == 11'h7ff) begin
                c1.fixed = 1'b1;
                c1.hi    = {c1.sign, dx80_pkg::EXT_EXP_ONES};
                c1.lo    = (frac != 52'd0) ? dx80_pkg::EXT_NAN_MAN : dx80_pkg::EXT_INF_MAN;
            end else if (ex11 != 11'd0) begin
                c1.fixed = 1'b1;
                c1.hi    = {c1.sign, {4'd0, ex11} + dx80_pkg::EXT_REBIAS};
                c1.lo    = {1'b1, frac, 11'd0};
            end else begin
                c1.lo    = {12'd0, frac};
            end
        end else begin
            c1.sign = iw.source_high[15];
            c1.ex   = iw.source_high[14:0];
            if (c1.ex == dx80_pkg::EXT_EXP_ONES) begin
                c1.fixed = 1'b1;
                c1.lo    = {c1.sign, (iw.source_low[62:0] != 63'd0) ?
                            dx80_pkg::DBL_QNAN : dx80_pkg::DBL_INF};
            end else if (iw.source_low == 64'd0) begin
                c1.fixed = 1'b1;
                c1.lo    = {c1.sign, 63'd0};
            end else begin
                c1.lo    = iw.source_low;
            end
        end
        // Priority encode the top set bit
        for (int i = 0; i < 64; i++) begin
            if (c1.lo[i]) begin
                c1.lz = 6'(63 - i);
            end
        end
    end

    dx80_stage #(.W(WW)) u_s2 (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(v1), .in_ready(r1), .in_data(c1),
        .out_valid(v2), .out_ready(r2), .out_data(w2)
    );

    // Normalize; widening of a subnormal double finishes here
    always_comb begin
        c2 = w2;
        if (!w2.fixed) begin
            c2.lo = w2.lo << w2.lz;
            if (w2.op == dx80_pkg::OP_WIDEN) begin
                c2.fixed = 1'b1;
                c2.hi    = {w2.sign, dx80_pkg::EXT_SUB_BASE - {9'd0, w2.lz}};
            end else begin
                c2.ue = $signed({2'b00, w2.ex}) - dx80_pkg::EXT_BIAS
                        - $signed({11'd0, w2.lz});
            end
        end
    end

    dx80_stage #(.W(WW)) u_s3 (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(v2), .in_ready(r2), .in_data(c2),
        .out_valid(v3), .out_ready(r3), .out_data(w3)
    );

    // Round to 53 bits, then check the exponent range
    always_comb begin
        logic        up;
        logic [53:0] sum;
        logic [52:0] q;
        logic signed [16:0] ue;
        logic signed [16:0] rr;
        c3  = w3;
        up  = w3.lo[10] && ((w3.lo[9:0] != 10'd0) || w3.lo[11]);
        sum = {1'b0, w3.lo[63:11]} + {53'd0, up};
        q   = sum[53] ? {1'b1, 52'd0} : sum[52:0];
        ue  = w3.ue + $signed({16'd0, sum[53]});
        rr  = -17'sd1022 - ue;
        if (!w3.fixed) begin
            c3.fixed = 1'b1;
            if (ue > 17'sd1023) begin
                c3.lo = {w3.sign, dx80_pkg::DBL_INF};
            end else if (ue >= -17'sd1022) begin
                c3.lo = {w3.sign, 11'(ue + 17'sd1023), q[51:0]};
            end else if (rr > 17'sd54) begin
                c3.lo = {w3.sign, 63'd0};
            end else begin
                c3.fixed = 1'b0;
                c3.lo    = {11'd0, q};
                c3.lz    = rr[5:0];
            end
        end
    end

    dx80_stage #(.W(WW)) u_s4 (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(v3), .in_ready(r3), .in_data(c3),
        .out_valid(v4), .out_ready(r4), .out_data(w4)
    );

    // Subnormal shift: keep half and sticky bits
    always_comb begin
        logic [63:0] hmask;
        logic        half;
        logic        sticky;
        logic [63:0] shr;
        c4     = w4;
        hmask  = (64'd1 << (w4.lz - 6'd1)) - 64'd1;
        half   = w4.lo[w4.lz - 6'd1];
        sticky = (w4.lo & hmask) != 64'd0;
        shr    = w4.lo >> w4.lz;
        if (!w4.fixed) begin
            c4.lo  = shr;
            c4.inc = half && (sticky || shr[0]);
        end
    end

    dx80_stage #(.W(WW)) u_s5 (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(v4), .in_ready(r4), .in_data(c4),
        .out_valid(v5), .out_ready(r5), .out_data(w5)
    );

    // Final increment and result word
    always_comb begin
        logic [63:0] rounded;
        rounded        = w5.lo + {63'd0, w5.inc};
        c5.result_high = (w5.op == dx80_pkg::OP_WIDEN) ? w5.hi : 16'd0;
        c5.result_low  = w5.fixed ? w5.lo : {w5.sign, rounded[62:0]};
    end

    dx80_stage #(.W(WO)) u_s6 (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(v5), .in_ready(r5), .in_data(c5),
        .out_valid(m_valid), .out_ready(m_ready), .out_data(m_data)
    );

endmodule

// ----- sim/double_extended80_converter_unit_test.sv -----
module double_extended80_converter_unit_test;
    import dx80_pkg::*;

    localparam int RANDOM_WORDS = 600;
    localparam int STALL_LIMIT  = 20000;
    localparam int DRAIN_CYCLES = 40;

    logic      aclk;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    in_word_t  s_data;
    logic      m_valid;
    logic      m_ready;
    out_word_t m_data;

    // Directed row: input word, plus a typed-in result where obvious
    typedef struct {
        in_word_t  word;
        logic      has_known;
        out_word_t known;
    } vector_t;

    out_word_t expected_results[$];
    int        mismatch_count;
    int        idle_cycles;
    bit        sending_done;
    bit        long_holdoff;
    bit        timed_out;

    double_extended80_converter_unit i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always begin
        aclk = 1'b0;
        #2;
        aclk = 1'b1;
        #2;
    end

    // Index of the highest set bit (value assumed nonzero)
    function automatic int msb_index(logic [63:0] v);
        int p;
        p = 0;
        for (int i = 0; i < 64; i++) begin
            if (v[i]) p = i;
        end
        return p;
    endfunction

    // Right shift by r (1..63), round to nearest even
    function automatic logic [63:0] round_shift(logic [63:0] v, int r);
        logic [63:0] q;
        logic [63:0] rem;
        logic [63:0] half;
        q    = v >> r;
        rem  = v & ((64'd1 << r) - 64'd1);
        half = 64'd1 << (r - 1);
        if (rem > half || (rem == half && q[0])) q = q + 64'd1;
        return q;
    endfunction

    // Double to extended, exact
    function automatic out_word_t widen_double(logic [63:0] bits);
        out_word_t   r;
        logic [10:0] dexp;
        logic [51:0] frac;
        int          p;
        dexp = bits[62:52];
        frac = bits[51:0];
        r.result_high = {bits[63], 15'd0};
        if (dexp == 11'd0 && frac == 52'd0) begin
            r.result_low = 64'd0;
        end else if (dexp == 11'h7ff) begin
            r.result_high[14:0] = 15'h7fff;
            r.result_low = (frac != 0) ? 64'hc000_0000_0000_0000 : 64'h8000_0000_0000_0000;
        end else if (dexp != 11'd0) begin
            r.result_high[14:0] = 15'(int'(dexp) - 1023 + 16383);
            r.result_low = {1'b1, frac, 11'd0};
        end else begin
            p = msb_index({12'd0, frac});
            r.result_high[14:0] = 15'(p - 1074 + 16383);
            r.result_low = {12'd0, frac} << (63 - p);
        end
        return r;
    endfunction

    // Extended to double, two-step nearest-even rounding
    function automatic logic [63:0] narrow_extended(logic [15:0] hi, logic [63:0] man);
        logic [63:0] sgn;
        logic [63:0] q;
        int          e, p, s, k, ue, r;
        sgn = {hi[15], 63'd0};
        e   = int'(hi[14:0]);
        if (hi[14:0] == 15'h7fff)
            return sgn | ((man[62:0] != 0) ? 64'h7ff8_0000_0000_0000 : 64'h7ff0_0000_0000_0000);
        if (man == 64'd0) return sgn;
        p = msb_index(man);
        q = man;
        s = 0;
        if (p > 52) begin
            s = p - 52;
            q = round_shift(man, s);
            if (q[53]) begin
                q = q >> 1;
                s++;
            end
        end else if (p < 52) begin
            q = q << (52 - p);
            s = p - 52;
        end
        k  = s + e - 16383 - 63;
        ue = k + 52;
        if (ue > 1023) return sgn | 64'h7ff0_0000_0000_0000;
        if (ue >= -1022) return sgn | {1'b0, 11'(ue + 1023), q[51:0]};
        r = -1074 - k;
        if (r > 54) return sgn;
        return sgn | round_shift(q, r);
    endfunction

    function automatic out_word_t convert_word(in_word_t w);
        out_word_t r;
        if (w.operation == OP_WIDEN) begin
            r = widen_double(w.source_low);
        end else begin
            r.result_high = 16'd0;
            r.result_low  = narrow_extended(w.source_high, w.source_low);
        end
        return r;
    endfunction

    function automatic vector_t make_row(logic op, logic [15:0] hi, logic [63:0] lo,
                                         logic has_known, logic [15:0] rh, logic [63:0] rl);
        vector_t v;
        v.word = '{operation: op, source_high: hi, source_low: lo};
        v.has_known = has_known;
        v.known = '{result_high: rh, result_low: rl};
        return v;
    endfunction

    // Random content biased toward the interesting exponent ranges
    function automatic in_word_t random_word();
        in_word_t    w;
        logic [63:0] lo;
        logic [14:0] ex;
        lo = {$urandom, $urandom};
        w.operation = 1'($urandom_range(0, 1));
        case ($urandom_range(0, 7))
            0: ex = 15'h7fff;
            1: ex = 15'($urandom_range(0, 3));
            2: ex = 15'($urandom_range(16383 - 1100, 16383 - 1000));
            3: ex = 15'($urandom_range(16383 + 1000, 16383 + 1030));
            4: ex = 15'($urandom_range(16383 - 1023, 16383 + 1023));
            default: ex = 15'($urandom);
        endcase
        if (w.operation == OP_WIDEN) begin
            case ($urandom_range(0, 5))
                0: lo[62:52] = 11'h7ff;
                1: lo[62:52] = 11'd0;
                2: lo[51:0] = (lo[0] ? 52'd0 : lo[51:0] >> $urandom_range(0, 51));
                default: ;
            endcase
        end else begin
            case ($urandom_range(0, 5))
                0: lo = lo >> $urandom_range(1, 63);
                1: lo = {1'b1, lo[62:11], 1'b1, 10'd0};
                2: lo = {lo[63:12], 1'b1, 11'd0};
                default: ;
            endcase
        end
        w.source_high = {lo[63] ^ lo[5], ex};
        w.source_low  = lo;
        return w;
    endfunction

    task automatic report_mismatch(out_word_t exp_word, out_word_t got_word);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("mismatch: expected hi=%h lo=%h, got hi=%h lo=%h",
                     exp_word.result_high, exp_word.result_low,
                     got_word.result_high, got_word.result_low);
    endtask

    // Idle gap; valid drops only when the gap is not empty
    task automatic wait_gap();
        int gap;
        gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // Hold valid and payload until accepted
    task automatic send_word(in_word_t w);
        s_data  <= w;
        s_valid <= 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic push_expected(vector_t v);
        out_word_t predicted;
        predicted = convert_word(v.word);
        if (v.has_known && predicted !== v.known) begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("table row disagrees with predictor: %h vs %h", v.known, predicted);
        end
        expected_results.push_back(v.has_known ? v.known : predicted);
    endtask

    // Result checker
    always @(posedge aclk) begin
        out_word_t exp_word;
        if (aresetn && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected word hi=%h lo=%h", m_data.result_high, m_data.result_low);
            end else begin
                exp_word = expected_results.pop_front();
                if (m_data.result_high !== exp_word.result_high ||
                    m_data.result_low !== exp_word.result_low)
                    report_mismatch(exp_word, m_data);
            end
        end
    end

    // Receiver: random stalls, one long hold-off while the sender keeps going
    always @(posedge aclk) begin
        int hold;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (long_holdoff) begin
            m_ready <= 1'b0;
            hold = 0;
            while (hold < 60) begin
                @(posedge aclk);
                hold++;
            end
            long_holdoff = 1'b0;
            m_ready <= 1'b1;
        end else if ($urandom_range(0, 19) == 0) begin
            m_ready <= 1'b0;
            repeat ($urandom_range(3, 25)) @(posedge aclk);
            m_ready <= 1'b1;
        end else begin
            m_ready <= ($urandom_range(0, 3) != 0);
        end
    end

    // Watchdog on cycles with no accepted word
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (expected_results.size() != 0 || !sending_done) begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) timed_out = 1'b1;
        end
    end

    initial begin
        vector_t directed[$];
        in_word_t w;
        mismatch_count = 0;
        idle_cycles = 0;
        sending_done = 1'b0;
        long_holdoff = 1'b0;
        timed_out = 1'b0;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data  = '0;

        // zeros, infinities, NaNs, extremes of both formats
        directed.push_back(make_row(OP_WIDEN, 16'h0, 64'h0, 1'b1, 16'h0000, 64'h0));
        directed.push_back(make_row(OP_WIDEN, 16'hffff, 64'h8000_0000_0000_0000, 1'b1,
                                    16'h8000, 64'h0));
        directed.push_back(make_row(OP_WIDEN, 16'h0, 64'h7ff0_0000_0000_0000, 1'b1,
                                    16'h7fff, 64'h8000_0000_0000_0000));
        directed.push_back(make_row(OP_WIDEN, 16'h0, 64'hfff0_0000_0000_0000, 1'b1,
                                    16'hffff, 64'h8000_0000_0000_0000));
        directed.push_back(make_row(OP_WIDEN, 16'h0, 64'h7ff0_0000_0000_0001, 1'b1,
                                    16'h7fff, 64'hc000_0000_0000_0000));
        directed.push_back(make_row(OP_WIDEN, 16'h0, 64'hffff_ffff_ffff_ffff, 1'b1,
                                    16'hffff, 64'hc000_0000_0000_0000));
        directed.push_back(make_row(OP_WIDEN, 16'h0, 64'h3ff0_0000_0000_0000, 1'b1,
                                    16'h3fff, 64'h8000_0000_0000_0000));
        directed.push_back(make_row(OP_WIDEN, 16'h0, 64'h0000_0000_0000_0001, 1'b0, '0, '0));
        directed.push_back(make_row(OP_WIDEN, 16'h0, 64'h000f_ffff_ffff_ffff, 1'b0, '0, '0));
        directed.push_back(make_row(OP_WIDEN, 16'h0, 64'h7fef_ffff_ffff_ffff, 1'b0, '0, '0));
        directed.push_back(make_row(OP_NARROW, 16'h7fff, 64'h8000_0000_0000_0000, 1'b1,
                                    16'h0, 64'h7ff0_0000_0000_0000));
        directed.push_back(make_row(OP_NARROW, 16'hffff, 64'h0, 1'b1,
                                    16'h0, 64'hfff0_0000_0000_0000));
        directed.push_back(make_row(OP_NARROW, 16'h7fff, 64'h4000_0000_0000_0000, 1'b1,
                                    16'h0, 64'h7ff8_0000_0000_0000));
        directed.push_back(make_row(OP_NARROW, 16'hffff, 64'hffff_ffff_ffff_ffff, 1'b1,
                                    16'h0, 64'hfff8_0000_0000_0000));
        directed.push_back(make_row(OP_NARROW, 16'h3fff, 64'h0, 1'b1, 16'h0, 64'h0));
        directed.push_back(make_row(OP_NARROW, 16'hbfff, 64'h0, 1'b1,
                                    16'h0, 64'h8000_0000_0000_0000));
        directed.push_back(make_row(OP_NARROW, 16'h3fff, 64'h8000_0000_0000_0000, 1'b1,
                                    16'h0, 64'h3ff0_0000_0000_0000));
        directed.push_back(make_row(OP_NARROW, 16'h0000, 64'hffff_ffff_ffff_ffff, 1'b1,
                                    16'h0, 64'h0));
        directed.push_back(make_row(OP_NARROW, 16'h7ffe, 64'hffff_ffff_ffff_ffff, 1'b1,
                                    16'h0, 64'h7ff0_0000_0000_0000));
        directed.push_back(make_row(OP_NARROW, 16'h3fff, 64'hffff_ffff_ffff_ffff, 1'b0, '0, '0));
        directed.push_back(make_row(OP_NARROW, 16'h3fff, 64'h8000_0000_0000_0400, 1'b0, '0, '0));
        directed.push_back(make_row(OP_NARROW, 16'h3fff, 64'h8000_0000_0000_0c00, 1'b0, '0, '0));
        directed.push_back(make_row(OP_NARROW, 16'h3c00, 64'hc000_0000_0000_0000, 1'b0, '0, '0));
        directed.push_back(make_row(OP_NARROW, 16'h3bcd, 64'h8000_0000_0000_0000, 1'b0, '0, '0));
        directed.push_back(make_row(OP_NARROW, 16'h3bcc, 64'hffff_ffff_ffff_ffff, 1'b0, '0, '0));

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        fork
            begin
                foreach (directed[i]) begin
                    push_expected(directed[i]);
                    send_word(directed[i].word);
                    wait_gap();
                end
                for (int n = 0; n < RANDOM_WORDS; n++) begin
                    w = random_word();
                    push_expected('{word: w, has_known: 1'b0, known: '0});
                    if (n == RANDOM_WORDS / 2) long_holdoff = 1'b1;
                    send_word(w);
                    if (n == RANDOM_WORDS - 1) break;
                    // back-to-back bursts keep valid high through the next word
                    if ($urandom_range(0, 2) != 0) continue;
                    wait_gap();
                end
                s_valid <= 1'b0;
                sending_done = 1'b1;
                while (expected_results.size() != 0) @(posedge aclk);
                repeat (DRAIN_CYCLES) @(posedge aclk);
            end
            begin
                wait (timed_out);
            end
        join_any

        if (!timed_out && mismatch_count == 0 && expected_results.size() == 0) begin
            $display("double_extended80_converter_unit_test passed");
        end else begin
            $display("double_extended80_converter_unit_test failed");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
hw/rtl/dx80_pkg.sv
hw/rtl/dx80_stage.sv
hw/rtl/double_extended80_converter_unit.sv
sim/double_extended80_converter_unit_test.sv
